@@ rtl/core/mrs_pkg.sv @@
// Shared types, direction codes and helpers for the monotonic run segmenter.
package mrs_pkg;

  // Default saturation limit for the run count
  localparam logic [31:0] MaxRunDefault = 32'd65535;

  // Run direction codes
  localparam logic [1:0] DirNone = 2'd0;
  localparam logic [1:0] DirRise = 2'd1;
  localparam logic [1:0] DirFall = 2'd2;

  // Most result words that one sample can cause
  localparam int unsigned MaxResults = 3;

  // One result word
  typedef struct packed {
    logic signed [16:0] run_length;
    logic signed [31:0] extremum_value;
    logic               final_point;
    logic               end_of_sequence;
  } mrs_res_t;

  // Result words handed from the tracker to the output queue together
  typedef struct packed {
    logic [1:0]                    num;
    mrs_res_t [MaxResults-1:0]     res;
  } mrs_push_t;

  // Signed length of a run: positive when rising, negative when falling
  function automatic logic signed [16:0] run_len(input logic [1:0] dir,
                                                 input logic [15:0] count);
    logic signed [16:0] len;
    len = '0;
    if (dir == DirRise) begin
      len = signed'({1'b0, count});
    end else if (dir == DirFall) begin
      len = -signed'({1'b0, count});
    end
    return len;
  endfunction

endpackage

@@ rtl/core/mrs_track.sv @@
// Run tracker: holds the run state and forms the result words of each sample.
module mrs_track #(
  parameter logic [31:0] MaxRun = mrs_pkg::MaxRunDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [31:0]       sample_i,
  input  logic              last_i,
  output mrs_pkg::mrs_push_t push_o
);
  import mrs_pkg::*;

  localparam logic [15:0] CountLimit = (MaxRun < 32'd65535) ? MaxRun[15:0] : 16'hFFFF;

  logic [31:0] prev_q;
  logic        have_prev_q;
  logic [1:0]  dir_q;
  logic [15:0] count_q;
  logic [31:0] start_q;

  logic [1:0]  dir_eff;
  logic [1:0]  step;
  logic        turn;
  logic [1:0]  dir_d;
  logic [15:0] count_d;
  logic [31:0] start_d;
  mrs_res_t    r_turn;
  mrs_res_t    r_open;
  mrs_res_t    r_fin;
  logic [1:0]  k;

  // Compare with the previous sample and advance the open run
  always_comb begin
    dir_eff = (dir_q == DirRise || dir_q == DirFall) ? dir_q : DirNone;
    if (signed'(sample_i) > signed'(prev_q)) begin
      step = DirRise;
    end else if (signed'(sample_i) < signed'(prev_q)) begin
      step = DirFall;
    end else begin
      step = DirNone;
    end
    turn    = have_prev_q && (dir_eff != DirNone) && (step != DirNone) && (step != dir_eff);
    dir_d   = dir_eff;
    count_d = count_q;
    start_d = start_q;
    if (have_prev_q) begin
      if (dir_eff == DirNone) begin
        if (step != DirNone) begin
          dir_d   = step;
          start_d = prev_q;
          count_d = 16'd2;
        end
      end else if (step == DirNone || step == dir_eff) begin
        if (count_q < CountLimit) begin
          count_d = count_q + 16'd1;
        end
      end else begin
        dir_d   = step;
        start_d = prev_q;
        count_d = 16'd2;
      end
    end
    if (count_d > CountLimit) begin
      count_d = CountLimit;
    end
  end

  // Candidate result words, packed together in order
  always_comb begin
    r_turn = '{run_length: run_len(dir_eff, count_q), extremum_value: signed'(start_q),
               final_point: 1'b0, end_of_sequence: 1'b0};
    r_open = '{run_length: run_len(dir_d, count_d), extremum_value: signed'(start_d),
               final_point: 1'b0, end_of_sequence: 1'b0};
    r_fin  = '{run_length: '0, extremum_value: signed'(sample_i),
               final_point: 1'b1, end_of_sequence: 1'b1};
    push_o.res = '0;
    k = 2'd0;
    if (turn) begin
      push_o.res[k] = r_turn;
      k = k + 2'd1;
    end
    if (last_i && dir_d != DirNone) begin
      push_o.res[k] = r_open;
      k = k + 2'd1;
    end
    if (last_i) begin
      push_o.res[k] = r_fin;
      k = k + 2'd1;
    end
    push_o.num = acc_i ? k : 2'd0;
  end

  // State update; the final sample returns the tracker to its reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      dir_q       <= DirNone;
      count_q     <= '0;
      start_q     <= '0;
    end else if (acc_i) begin
      if (last_i) begin
        prev_q      <= '0;
        have_prev_q <= 1'b0;
        dir_q       <= DirNone;
        count_q     <= '0;
        start_q     <= '0;
      end else begin
        prev_q      <= sample_i;
        have_prev_q <= 1'b1;
        dir_q       <= dir_d;
        count_q     <= count_d;
        start_q     <= start_d;
      end
    end
  end

  // An open run always has a previous sample behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q != DirNone |-> have_prev_q)
    else $error("run open without a previous sample");

  // An open run spans at least two samples and never passes the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q != DirNone |-> (count_q >= 16'd2 && count_q <= CountLimit))
    else $error("run count out of range");

  // The final sample leaves no previous sample behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && last_i |=> !have_prev_q && dir_q == DirNone)
    else $error("state not cleared after final sample");

endmodule

@@ rtl/core/mrs_queue.sv @@
// Output queue: four result registers, up to three written and one read per cycle.
module mrs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mrs_pkg::mrs_push_t push_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output mrs_pkg::mrs_res_t  res_o
);
  import mrs_pkg::*;

  localparam int unsigned Depth = 4;

  mrs_res_t   mem_q [Depth];
  logic [1:0] wr_q;
  logic [1:0] rd_q;
  logic [2:0] cnt_q;
  logic [2:0] cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign pop     = valid_o && ready_i;
  assign res_o   = mem_q[rd_q];
  // Room for the largest burst a single sample can cause
  assign room_o  = (cnt_q <= 3'(Depth - MaxResults));
  assign cnt_d   = cnt_q + {1'b0, push_i.num} - {2'b00, pop};

  // Result storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (2'(i) < push_i.num) begin
        mem_q[wr_q + 2'(i)] <= push_i.res[i];
      end
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.num;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_d;
    end
  end

  // Writes never land on words still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> ({1'b0, cnt_q} + {2'b00, push_i.num}) <= 4'(Depth))
    else $error("result queue overflow");

  // The fill count follows the pointers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(Depth) && (cnt_q[1:0] == 2'(wr_q - rd_q)))
    else $error("result queue count out of step with pointers");

endmodule

@@ rtl/core/monotonic_run_segmenter.sv @@
// Top level of the monotonic run segmenter: splits a sample stream into one-way runs.
//
//  channel  dir  tdata                                   side bands
//  s_axis   in   [31:0] sample                           tlast = last
//  m_axis   out  [16:0] run_length, [48:17] extremum     tuser = final_point,
//                 value, [55:49] zero                    tlast = end_of_sequence
//
// One sample is accepted every cycle while s_axis_tready is high; its results enter the
// output queue at the same edge and, if it was empty, the first can be taken in the next cycle.
// The final sample of a sequence causes up to three result words, which leave
// at one word per cycle while m_axis_tready is high; the four-word output queue
// sets when input stalls, and s_axis_tready is high while at most one word waits.
// Reset clears the run state and empties the queue.
module monotonic_run_segmenter #(
  parameter logic [31:0] MaxRun = mrs_pkg::MaxRunDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [16:0] run_length, [48:17] extremum_value, rest zero
  output logic        m_axis_tuser,   // [0] final_point
  output logic        m_axis_tlast
);
  import mrs_pkg::*;

  logic      in_acc;
  mrs_push_t push;
  mrs_res_t  res;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Run tracking
  mrs_track #(
    .MaxRun(MaxRun)
  ) u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (in_acc),
    .sample_i(s_axis_tdata),
    .last_i  (s_axis_tlast),
    .push_o  (push)
  );

  // Result queue
  mrs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (s_axis_tready),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .res_o  (res)
  );

  // Output word packing
  assign m_axis_tdata = {7'd0, res.extremum_value, res.run_length};
  assign m_axis_tuser = res.final_point;
  assign m_axis_tlast = res.end_of_sequence;

endmodule
